FILE: hw/rtl/gcm_pkg.sv
package gcm_pkg;

  localparam int VERTICES   = 256;
  localparam int COUNT_BITS = 16;

  localparam int CELLS    = VERTICES * VERTICES;
  localparam int VBITS    = $clog2(VERTICES);
  localparam int ABITS    = $clog2(CELLS);
  localparam int LT_BITS  = $clog2(VERTICES + 1);
  localparam int SUM_BITS = COUNT_BITS + ABITS;

  localparam int OP_W   = 2;
  localparam int VTX_W  = 8;
  localparam int STAT_W = 2;
  localparam int LIVE_W = 9;
  localparam int CUT_W  = 23;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam int MIN_LIVE = 3;
  localparam int CUT_MAX  = 8388607;
  localparam int LIVE_MAX = 511;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ODD = 2'd1;
  localparam logic [STAT_W-1:0] ST_FEW = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd3;

  localparam int MC_W = 3;
  localparam logic [MC_W-1:0] MC_NOP     = 3'd0;
  localparam logic [MC_W-1:0] MC_CLEAR   = 3'd1;
  localparam logic [MC_W-1:0] MC_LOAD    = 3'd2;
  localparam logic [MC_W-1:0] MC_MERGE   = 3'd3;
  localparam logic [MC_W-1:0] MC_SUM     = 3'd4;
  localparam logic [MC_W-1:0] MC_ACC_CLR = 3'd5;

  typedef struct packed {
    logic [MC_W-1:0]  kind;
    logic [ABITS-1:0] addr_a;
    logic [ABITS-1:0] addr_b;
    logic [VBITS-1:0] col;
    logic [VBITS-1:0] va;
    logic [VBITS-1:0] vb;
  } mem_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LIVE_W-1:0] live_count;
    logic [CUT_W-1:0]  cut;
  } res_t;

endpackage

FILE: hw/rtl/gcm_store.sv
module gcm_store import gcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  mem_cmd_t            cmd,
  output logic [SUM_BITS-1:0] acc
);

  localparam logic [SUM_BITS-1:0] CAP = {{(SUM_BITS - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  logic [COUNT_BITS-1:0] edge_mem [CELLS];
  logic [VBITS-1:0]      grp_mem  [VERTICES];

  logic [COUNT_BITS-1:0] rd_a_r;
  logic [COUNT_BITS-1:0] rd_b_r;
  logic [VBITS-1:0]      grp_rd_r;
  mem_cmd_t              cmd_r;
  logic [MC_W-1:0]       kind_r;
  logic [SUM_BITS-1:0]   acc_r;
  logic [SUM_BITS-1:0]   acc_nxt;

  logic [SUM_BITS-1:0]   op_x;
  logic [SUM_BITS-1:0]   op_y;
  logic [SUM_BITS-1:0]   sum;
  logic [COUNT_BITS-1:0] sat;
  logic [VBITS-1:0]      grp_new;
  logic                  edge_we;
  logic [COUNT_BITS-1:0] edge_wd;
  logic                  grp_we;
  logic [VBITS-1:0]      grp_wa;
  logic [VBITS-1:0]      grp_wd;

  // read stage
  always_ff @(posedge clk) begin
    rd_a_r   <= edge_mem[cmd.addr_a];
    rd_b_r   <= edge_mem[cmd.addr_b];
    grp_rd_r <= grp_mem[cmd.col];
    cmd_r    <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= MC_NOP;
    end else begin
      kind_r <= cmd.kind;
    end
  end

  // shared adder
  always_comb begin
    grp_new = (grp_rd_r == cmd_r.vb) ? cmd_r.va : grp_rd_r;
    case (kind_r)
      MC_LOAD: begin
        op_x = SUM_BITS'(rd_a_r);
        op_y = SUM_BITS'(1);
      end
      MC_MERGE: begin
        op_x = SUM_BITS'(rd_a_r);
        op_y = SUM_BITS'(rd_b_r);
      end
      MC_SUM: begin
        op_x = acc_r;
        op_y = SUM_BITS'(rd_a_r);
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
    sum = op_x + op_y;
    sat = (sum > CAP) ? CAP[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
  end

  always_comb begin
    edge_we = 1'b0;
    edge_wd = '0;
    grp_we  = 1'b0;
    grp_wa  = cmd_r.col;
    grp_wd  = grp_new;
    acc_nxt = acc_r;
    case (kind_r)
      MC_CLEAR: begin
        edge_we = 1'b1;
        grp_we  = (cmd_r.addr_a < ABITS'(VERTICES));
        grp_wa  = VBITS'(cmd_r.addr_a);
        grp_wd  = VBITS'(cmd_r.addr_a);
      end
      MC_LOAD: begin
        edge_we = 1'b1;
        edge_wd = sat;
      end
      MC_MERGE: begin
        edge_we = 1'b1;
        edge_wd = (grp_new == cmd_r.va) ? '0 : sat;
        grp_we  = 1'b1;
      end
      MC_SUM: begin
        acc_nxt = sum;
      end
      MC_ACC_CLR: begin
        acc_nxt = '0;
      end
      default: begin
        edge_we = 1'b0;
      end
    endcase
  end

  // write stage
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[cmd_r.addr_a] <= edge_wd;
    end
    if (grp_we) begin
      grp_mem[grp_wa] <= grp_wd;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

FILE: hw/rtl/gcm_seq.sv
module gcm_seq import gcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [VTX_W-1:0]    in_a,
  input  logic [VTX_W-1:0]    in_b,
  output mem_cmd_t            cmd,
  input  logic [SUM_BITS-1:0] acc,
  output logic                res_valid,
  output res_t                res,
  input  logic                res_take
);

  localparam int SW = 3;
  localparam logic [SW-1:0] S_CLEAR = 3'd0;
  localparam logic [SW-1:0] S_IDLE  = 3'd1;
  localparam logic [SW-1:0] S_LOAD  = 3'd2;
  localparam logic [SW-1:0] S_MERGE = 3'd3;
  localparam logic [SW-1:0] S_QINIT = 3'd4;
  localparam logic [SW-1:0] S_QRUN  = 3'd5;
  localparam logic [SW-1:0] S_QWAIT = 3'd6;
  localparam logic [SW-1:0] S_DONE  = 3'd7;

  localparam logic [VBITS-1:0] LAST_V = VBITS'(VERTICES - 1);
  localparam logic [ABITS-1:0] LAST_C = ABITS'(CELLS - 1);

  logic [SW-1:0]         state_r, state_nxt;
  logic [ABITS-1:0]      cnt_r, cnt_nxt;
  logic [VBITS-1:0]      col_r, col_nxt;
  logic [VBITS-1:0]      row_r, row_nxt;
  logic [VBITS-1:0]      va_r, va_nxt;
  logic [VBITS-1:0]      vb_r, vb_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [VERTICES-1:0]   live_r, live_nxt;
  logic [LT_BITS-1:0]    live_total_r, live_total_nxt;

  logic                  accept;
  logic                  a_ok;
  logic                  b_ok;
  logic [VBITS-1:0]      ia;
  logic [VBITS-1:0]      ib;
  logic [SUM_BITS-1:0]   half;

  function automatic logic [ABITS-1:0] cell_addr(logic [VBITS-1:0] r, logic [VBITS-1:0] c);
    return ABITS'(r) * ABITS'(VERTICES) + ABITS'(c);
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ia       = VBITS'(in_a);
  assign ib       = VBITS'(in_b);
  assign a_ok     = (32'(in_a) < VERTICES);
  assign b_ok     = (32'(in_b) < VERTICES);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    va_nxt         = va_r;
    vb_nxt         = vb_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    live_nxt       = live_r;
    live_total_nxt = live_total_r;
    cmd            = '0;
    cmd.kind       = MC_NOP;
    case (state_r)
      S_CLEAR: begin
        cmd.kind   = MC_CLEAR;
        cmd.addr_a = cnt_r;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_C) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_op;
          va_nxt     = ia;
          vb_nxt     = ib;
          col_nxt    = '0;
          row_nxt    = '0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_op)
            OP_LOAD: begin
              if (a_ok && b_ok) begin
                state_nxt = S_LOAD;
              end else begin
                status_nxt = ST_BAD;
              end
            end
            OP_MERGE: begin
              if (32'(live_total_r) < MIN_LIVE) begin
                status_nxt = ST_FEW;
              end else if (!a_ok || !b_ok || in_a == in_b || !live_r[ia] || !live_r[ib]) begin
                status_nxt = ST_BAD;
              end else begin
                live_nxt[ib]   = 1'b0;
                live_total_nxt = live_total_r - 1'b1;
                state_nxt      = S_MERGE;
              end
            end
            OP_QUERY: begin
              state_nxt = S_QINIT;
            end
            default: begin
              status_nxt = ST_BAD;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.kind   = MC_LOAD;
        cmd.addr_a = cell_addr(va_r, vb_r);
        state_nxt  = S_DONE;
      end
      S_MERGE: begin
        cmd.kind   = MC_MERGE;
        cmd.addr_a = cell_addr(va_r, col_r);
        cmd.addr_b = cell_addr(vb_r, col_r);
        cmd.col    = col_r;
        cmd.va     = va_r;
        cmd.vb     = vb_r;
        col_nxt    = col_r + 1'b1;
        if (col_r == LAST_V) begin
          state_nxt = S_DONE;
        end
      end
      S_QINIT: begin
        cmd.kind  = MC_ACC_CLR;
        state_nxt = S_QRUN;
      end
      S_QRUN: begin
        if (live_r[row_r]) begin
          cmd.kind   = MC_SUM;
          cmd.addr_a = cell_addr(row_r, col_r);
          col_nxt    = col_r + 1'b1;
          if (col_r == LAST_V) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
            if (row_r == LAST_V) begin
              state_nxt = S_QWAIT;
            end
          end
        end else begin
          row_nxt = row_r + 1'b1;
          if (row_r == LAST_V) begin
            state_nxt = S_QWAIT;
          end
        end
      end
      S_QWAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result formation
  always_comb begin
    half           = acc >> 1;
    res.live_count = (32'(live_total_r) > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live_total_r);
    if (op_r == OP_QUERY) begin
      res.status = acc[0] ? ST_ODD : ST_OK;
      res.cut    = (64'(half) > 64'(CUT_MAX)) ? CUT_W'(CUT_MAX) : CUT_W'(half);
    end else begin
      res.status = status_r;
      res.cut    = '0;
    end
  end

  assign res_valid = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      live_r       <= '1;
      live_total_r <= LT_BITS'(VERTICES);
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      live_r       <= live_nxt;
      live_total_r <= live_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    va_r     <= va_nxt;
    vb_r     <= vb_nxt;
    op_r     <= op_nxt;
    status_r <= status_nxt;
  end

endmodule

FILE: hw/rtl/graph_contraction_min_cut.sv
// Contraction engine for min-cut on a multigraph held as a matrix of
// saturating edge counts, one row per super vertex.
// Input channel in_*: one item per command (load entry, contract pair,
// query cut size); the host picks the pair to contract.
// Result channel out_*: exactly one item per input item, in order,
// carrying status, live vertex count and cut size.
// Rejected items go straight to the result; a load updates one entry;
// a contraction runs one column per cycle through a single saturating
// adder with two row reads and one write per cycle on the count memory;
// a query sums every live row column by column and steps over each
// dead row.
// A new item is accepted the cycle after the previous result moves into
// the output register, so the block takes input while a result waits.
// After reset the count memory is swept to zero and the group table set
// to identity over all VERTICES * VERTICES cells (65536) with in_tready low.
// When the receiver stalls the result is held in the output register;
// the next item runs and then waits for that register to free.
module graph_contraction_min_cut import gcm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode[1:0], first_vertex[9:2], second_vertex[17:10]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], live_count[10:2], cut_edges[33:11]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  mem_cmd_t            cmd;
  logic [SUM_BITS-1:0] acc;
  logic                res_valid;
  res_t                res;
  logic                res_take;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r;

  gcm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_a      (in_tdata[9:2]),
    .in_b      (in_tdata[17:10]),
    .cmd       (cmd),
    .acc       (acc),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  gcm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc)
  );

  // output register
  assign res_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - STAT_W - LIVE_W - CUT_W){1'b0}},
                       out_res_r.cut, out_res_r.live_count, out_res_r.status};

endmodule
